[hw/rtl/sfr_pkg.sv]
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

  localparam int unsigned SfrByteW        = 8;
  localparam int unsigned SfrMaxBytes     = 8;   // widest burst one item can cause
  localparam int unsigned SfrLenW         = 4;   // width of a length register
  localparam int unsigned SfrWordW        = SfrByteW * SfrMaxBytes;
  localparam int unsigned SfrPatternBytes = 8;
  localparam int unsigned SfrQueueDepth   = 4;   // power of two
  localparam int unsigned SfrCfgIdxW      = 8;

  typedef enum logic [SfrCfgIdxW-1:0] {
    CfgMatchPattern = 8'd0,
    CfgMatchLength  = 8'd1,
    CfgReplPattern  = 8'd2,
    CfgReplLength   = 8'd3
  } cfg_idx_e;

  // configuration write as seen by the front end
  typedef struct packed {
    logic                  valid;
    logic [SfrCfgIdxW-1:0] index;
    logic [SfrWordW-1:0]   data;
  } cfg_wr_t;

  // burst descriptor: count bytes of data, then end of string if last
  typedef struct packed {
    logic [SfrWordW-1:0] data;
    logic [SfrLenW-1:0]  count;
    logic                last;
  } desc_t;

endpackage

[hw/rtl/stream_find_replace.sv]
// top level of the streaming find-and-replace block
// path: a result goes through the descriptor queue, then the back end unpacks it into the output register
// throughput: one byte per cycle in unless full; one result per cycle out while popped, set by the back end unpacking
// a replacement burst of n bytes comes out as n single bytes; a four-entry queue soaks up bursts
// reset: config registers and counters zero, window empty, queue and output register empty; no clearing pass
module stream_find_replace #(
  parameter int unsigned PatternBytes = sfr_pkg::SfrPatternBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfr_pkg::SfrCfgIdxW-1:0]  cfg_index_i,
  input  logic [sfr_pkg::SfrWordW-1:0]    cfg_data_i,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic [sfr_pkg::SfrByteW-1:0]    in_byte_i,
  input  logic                            in_last_i,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic [sfr_pkg::SfrByteW-1:0]    out_byte_o,
  output logic                            has_byte_o,
  output logic                            out_last_o
);
  import sfr_pkg::*;

  cfg_wr_t cfg_wr;
  desc_t   front_desc, head_desc;
  logic    front_valid, q_empty, q_full, q_pop, accept;

  // registers take a write on any cycle
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // a byte is taken whenever the queue has room, even if it yields nothing yet
  assign full   = q_full;
  assign accept = push && !q_full;

  // front end: window update and classification into at most one burst per accepted byte
  sfr_front #(
    .PatternBytes (PatternBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .desc_o       (front_desc),
    .desc_valid_o (front_valid)
  );

  // decoupling queue of burst descriptors
  sfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_desc_i (front_desc),
    .rd_i      (q_pop),
    .rd_desc_o (head_desc),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  // back end: one result byte (or end marker) per cycle into the output register while its slot is free
  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (head_desc),
    .desc_empty_i (q_empty),
    .desc_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule

[hw/rtl/sfr_front.sv]
// front end: configuration registers, pending window and match classification
module sfr_front #(
  parameter int unsigned PatternBytes = sfr_pkg::SfrPatternBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfr_pkg::cfg_wr_t              cfg_i,
  input  logic                          accept_i,
  input  logic [sfr_pkg::SfrByteW-1:0]  in_byte_i,
  input  logic                          in_last_i,
  output sfr_pkg::desc_t                desc_o,
  output logic                          desc_valid_o
);
  import sfr_pkg::*;

  localparam int unsigned CntW = $clog2(PatternBytes + 1);
  localparam int unsigned IdxW = (PatternBytes > 1) ? $clog2(PatternBytes) : 1;

  logic [SfrWordW-1:0] match_pattern_q, repl_pattern_q;
  logic [SfrLenW-1:0]  match_length_q, repl_length_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SfrByteW-1:0] win_q [PatternBytes];

  logic [SfrLenW-1:0]  mlen, rlen, cnt_ext, cnt_inc;
  logic [SfrWordW-1:0] wnew;
  logic [PatternBytes-1:0] byte_eq;
  logic                full, hit, shift, append;

  // effective lengths
  assign mlen = (match_length_q > SfrLenW'(PatternBytes)) ? SfrLenW'(PatternBytes)
                                                         : match_length_q;
  assign rlen = (repl_length_q > SfrLenW'(SfrMaxBytes)) ? SfrLenW'(SfrMaxBytes)
                                                       : repl_length_q;

  assign cnt_ext = SfrLenW'(cnt_q);
  assign cnt_inc = cnt_ext + SfrLenW'(1);

  // window with the new byte in place
  for (genvar g = 0; g < SfrMaxBytes; g++) begin : g_wnew
    if (g < PatternBytes) begin : g_live
      assign wnew[g*SfrByteW +: SfrByteW] =
        (cnt_q == CntW'(g)) ? in_byte_i : win_q[g];
      assign byte_eq[g] = (SfrLenW'(g) >= mlen) ||
        (wnew[g*SfrByteW +: SfrByteW] == match_pattern_q[g*SfrByteW +: SfrByteW]);
    end else begin : g_pad
      assign wnew[g*SfrByteW +: SfrByteW] = '0;
    end
  end

  assign full   = (mlen != '0) && (cnt_inc == mlen);
  assign hit    = full && (&byte_eq);
  assign shift  = accept_i && full && !hit && !in_last_i;
  assign append = accept_i && (mlen != '0) && !full && !in_last_i;

  always_comb begin
    desc_o.last = in_last_i;
    cnt_d       = cnt_q;
    if (mlen == '0) begin
      desc_o.data  = {{(SfrWordW-SfrByteW){1'b0}}, in_byte_i};
      desc_o.count = SfrLenW'(1);
    end else if (hit) begin
      desc_o.data  = repl_pattern_q;
      desc_o.count = rlen;
    end else begin
      desc_o.data  = wnew;
      if (in_last_i)  desc_o.count = cnt_inc;
      else if (full)  desc_o.count = SfrLenW'(1);
      else            desc_o.count = '0;
    end
    if (accept_i) begin
      if ((mlen == '0) || hit || in_last_i) cnt_d = '0;
      else if (full)                        cnt_d = CntW'(mlen - SfrLenW'(1));
      else                                  cnt_d = CntW'(cnt_inc);
    end
    if (cfg_i.valid && (cfg_i.index == CfgMatchLength)) cnt_d = '0;
  end

  assign desc_valid_o = accept_i && ((desc_o.count != '0) || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_pattern_q <= '0;
      match_length_q  <= '0;
      repl_pattern_q  <= '0;
      repl_length_q   <= '0;
      cnt_q           <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgMatchPattern: match_pattern_q <= cfg_i.data;
          CfgMatchLength:  match_length_q  <= cfg_i.data[SfrLenW-1:0];
          CfgReplPattern:  repl_pattern_q  <= cfg_i.data;
          CfgReplLength:   repl_length_q   <= cfg_i.data[SfrLenW-1:0];
          default: ;
        endcase
      end
    end
  end

  // pending bytes, oldest in entry 0
  for (genvar g = 0; g < PatternBytes; g++) begin : g_win
    if (g + 1 < PatternBytes) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (shift) begin
          win_q[g] <= wnew[(g+1)*SfrByteW +: SfrByteW];
        end else if (append && (cnt_q[IdxW-1:0] == IdxW'(g))) begin
          win_q[g] <= in_byte_i;
        end
      end
    end else begin : g_top
      // top entry is never read after a shift, so it just holds
      always_ff @(posedge clk_i) begin
        if (!shift && append && (cnt_q[IdxW-1:0] == IdxW'(g))) begin
          win_q[g] <= in_byte_i;
        end
      end
    end
  end

endmodule

[hw/rtl/sfr_queue.sv]
// short descriptor queue between front and back end
module sfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  sfr_pkg::desc_t wr_desc_i,
  input  logic           rd_i,
  output sfr_pkg::desc_t rd_desc_o,
  output logic           empty_o,
  output logic           full_o
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = $clog2(SfrQueueDepth);

  desc_t           mem_q [SfrQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic            do_wr, do_rd;

  assign empty_o   = (fill_q == '0);
  assign full_o    = (fill_q == (PtrW+1)'(SfrQueueDepth));
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_desc_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd)      fill_q <= fill_q + (PtrW+1)'(1);
      else if (do_rd && !do_wr) fill_q <= fill_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_desc_i;
  end

endmodule

[hw/rtl/sfr_back.sv]
// back end: unpacks descriptors into single bytes behind an output register
module sfr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfr_pkg::desc_t                desc_i,
  input  logic                          desc_empty_i,
  output logic                          desc_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [sfr_pkg::SfrByteW-1:0]  out_byte_o,
  output logic                          has_byte_o,
  output logic                          out_last_o
);
  import sfr_pkg::*;

  localparam int unsigned PosW = $clog2(SfrMaxBytes);

  logic [PosW-1:0]     pos_q;
  logic                valid_q;
  logic [SfrByteW-1:0] byte_q;
  logic                has_q, last_q;
  logic                slot_free, take, final_byte, marker;

  assign slot_free  = !valid_q || pop_i;
  assign take       = slot_free && !desc_empty_i;
  assign marker     = (desc_i.count == '0);
  assign final_byte = marker || ((SfrLenW'(pos_q) + SfrLenW'(1)) == desc_i.count);
  assign desc_pop_o = take && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (slot_free) valid_q <= !desc_empty_i;
      if (take) pos_q <= final_byte ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= marker ? '0 : desc_i.data[pos_q*SfrByteW +: SfrByteW];
      has_q  <= !marker;
      last_q <= desc_i.last && final_byte;
    end
  end

  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;
  assign has_byte_o = has_q;
  assign out_last_o = last_q;

endmodule
